/* design/dgcd_pkg.sv */
// Shared constants and types for the directed graph cycle detector.
// Holds the command codes, field widths and the control structs between modules.
// No dependencies.
package dgcd_pkg;

	localparam int CMD_W = 2;
	localparam int VTX_W = 6;
	localparam int CNT_W = 7;

	localparam int MAX_VERTICES_DEF = 64;
	localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] COL_WHITE = 2'd0;
	localparam logic [1:0] COL_GRAY  = 2'd1;
	localparam logic [1:0] COL_BLACK = 2'd2;

	typedef struct packed {
		logic             add;
		logic             clear;
		logic [VTX_W-1:0] src;
		logic [VTX_W-1:0] dst;
	} adj_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} adj_stat_t;

	typedef struct packed {
		logic done;
		logic found;
	} dfs_stat_t;

endpackage

/* design/dgcd_ifs.sv */
// Valid/ready channel interfaces of the directed graph cycle detector.
// Request, response and configuration channels. Depends on dgcd_pkg.
interface dgcd_req_if import dgcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [VTX_W-1:0] src_vertex;
	logic [VTX_W-1:0] dst_vertex;

	modport source (output valid, cmd, src_vertex, dst_vertex, input ready);
	modport sink   (input valid, cmd, src_vertex, dst_vertex, output ready);
endinterface

interface dgcd_rsp_if import dgcd_pkg::*; ();
	logic valid;
	logic ready;
	logic has_cycle;
	logic status;

	modport source (output valid, has_cycle, status, input ready);
	modport sink   (input valid, has_cycle, status, output ready);
endinterface

interface dgcd_cfg_if import dgcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] vertex_count;

	modport source (output valid, vertex_count, input ready);
	modport sink   (input valid, vertex_count, output ready);
endinterface

/* design/dgcd_adj.sv */
// Adjacency matrix store: one row per vertex in a synchronous memory.
// Performs edge insertion by read-modify-write and whole-matrix clearing sweeps.
// Depends on dgcd_pkg.
module dgcd_adj import dgcd_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  adj_ctl_t                      ctl,
	input  logic                          rd_en,
	input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
	output logic [MAX_VERTICES-1:0]       row,
	output adj_stat_t                     stat
);

	localparam int VW = $clog2(MAX_VERTICES);

	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_q;
	logic                    sweep_q;
	logic                    sweep_cmd_q;
	logic [VW-1:0]           sweep_cnt_q;
	logic                    add_wr_q;
	logic [VW-1:0]           src_q;
	logic [VW-1:0]           dst_q;
	logic                    sweep_last;
	logic [MAX_VERTICES-1:0] bit_mask;
	logic                    we;
	logic [VW-1:0]           wa;
	logic [MAX_VERTICES-1:0] wd;
	logic                    re;
	logic [VW-1:0]           ra;

	assign sweep_last = (sweep_cnt_q == VW'(MAX_VERTICES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cmd_q <= 1'b0;
			sweep_cnt_q <= '0;
			add_wr_q    <= 1'b0;
		end else begin
			add_wr_q <= ctl.add;
			if (ctl.clear) begin
				sweep_q     <= 1'b1;
				sweep_cmd_q <= 1'b1;
				sweep_cnt_q <= '0;
			end else if (sweep_q) begin
				sweep_cnt_q <= sweep_cnt_q + VW'(1);
				if (sweep_last) begin
					sweep_q     <= 1'b0;
					sweep_cmd_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add) begin
			src_q <= VW'(ctl.src);
			dst_q <= VW'(ctl.dst);
		end
	end

	always_comb begin
		bit_mask        = '0;
		bit_mask[dst_q] = 1'b1;
	end

	assign we = sweep_q | add_wr_q;
	assign wa = sweep_q ? sweep_cnt_q : src_q;
	assign wd = sweep_q ? '0 : (row_q | bit_mask);
	assign re = ctl.add | rd_en;
	assign ra = ctl.add ? VW'(ctl.src) : rd_addr;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			row_q <= mem[ra];
		end
	end

	assign row       = row_q;
	assign stat.busy = sweep_q;
	assign stat.done = add_wr_q | (sweep_q & sweep_cmd_q & sweep_last);

endmodule

/* design/dgcd_dfs.sv */
// Depth-first search engine with three vertex colours and an explicit stack.
// Colour and stack live in synchronous memories; rows come from dgcd_adj.
// Depends on dgcd_pkg.
module dgcd_dfs import dgcd_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [$clog2(MAX_VERTICES+1)-1:0] n,
	output logic                              rd_en,
	output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
	input  logic [MAX_VERTICES-1:0]           row,
	output dfs_stat_t                         stat
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int SW = VW + NW;

	localparam logic [2:0] D_IDLE    = 3'd0;
	localparam logic [2:0] D_INIT    = 3'd1;
	localparam logic [2:0] D_ROOT    = 3'd2;
	localparam logic [2:0] D_ROOTCHK = 3'd3;
	localparam logic [2:0] D_SCAN    = 3'd4;
	localparam logic [2:0] D_COL     = 3'd5;
	localparam logic [2:0] D_POP     = 3'd6;

	logic [1:0]    colour_mem [MAX_VERTICES];
	logic [SW-1:0] stack_mem  [MAX_VERTICES];

	logic [2:0]    state_q, state_d;
	logic [NW-1:0] root_q, root_d;
	logic [NW-1:0] depth_q, depth_d;
	logic [NW-1:0] next_q, next_d;
	logic [VW-1:0] here_q, here_d;
	logic [VW-1:0] nb_q, nb_d;
	logic [1:0]    col_rd_q;
	logic [SW-1:0] stk_rd_q;

	logic          col_we, col_re;
	logic [VW-1:0] col_wa, col_ra;
	logic [1:0]    col_wd;
	logic          stk_we, stk_re;
	logic [VW-1:0] stk_wa, stk_ra;
	logic [SW-1:0] stk_wd;

	logic [NW-1:0] root_inc, next_inc, depth_m1, depth_m2;

	assign root_inc = root_q + NW'(1);
	assign next_inc = next_q + NW'(1);
	assign depth_m1 = depth_q - NW'(1);
	assign depth_m2 = depth_q - NW'(2);

	always_comb begin
		state_d    = state_q;
		root_d     = root_q;
		depth_d    = depth_q;
		next_d     = next_q;
		here_d     = here_q;
		nb_d       = nb_q;
		col_we     = 1'b0;
		col_wa     = root_q[VW-1:0];
		col_wd     = COL_WHITE;
		col_re     = 1'b0;
		col_ra     = root_q[VW-1:0];
		stk_we     = 1'b0;
		stk_wa     = depth_m1[VW-1:0];
		stk_wd     = {here_q, next_q};
		stk_re     = 1'b0;
		stk_ra     = depth_m2[VW-1:0];
		rd_en      = 1'b0;
		rd_addr    = root_q[VW-1:0];
		stat.done  = 1'b0;
		stat.found = 1'b0;
		case (state_q)
			D_IDLE: begin
				if (start) begin
					root_d  = '0;
					depth_d = '0;
					state_d = (n == '0) ? D_ROOT : D_INIT;
				end
			end
			D_INIT: begin
				col_we = 1'b1;
				root_d = root_inc;
				if (root_inc == n) begin
					root_d  = '0;
					state_d = D_ROOT;
				end
			end
			D_ROOT: begin
				if (root_q == n) begin
					stat.done = 1'b1;
					state_d   = D_IDLE;
				end else begin
					col_re  = 1'b1;
					state_d = D_ROOTCHK;
				end
			end
			D_ROOTCHK: begin
				if (col_rd_q != COL_WHITE) begin
					root_d  = root_inc;
					state_d = D_ROOT;
				end else begin
					col_we  = 1'b1;
					col_wd  = COL_GRAY;
					here_d  = root_q[VW-1:0];
					next_d  = '0;
					depth_d = NW'(1);
					rd_en   = 1'b1;
					state_d = D_SCAN;
				end
			end
			D_SCAN: begin
				if (next_q == n) begin
					col_we  = 1'b1;
					col_wa  = here_q;
					col_wd  = COL_BLACK;
					depth_d = depth_m1;
					if (depth_q == NW'(1)) begin
						root_d  = root_inc;
						state_d = D_ROOT;
					end else begin
						stk_re  = 1'b1;
						state_d = D_POP;
					end
				end else begin
					next_d = next_inc;
					if (row[next_q[VW-1:0]]) begin
						col_re  = 1'b1;
						col_ra  = next_q[VW-1:0];
						nb_d    = next_q[VW-1:0];
						state_d = D_COL;
					end
				end
			end
			D_COL: begin
				state_d = D_SCAN;
				if (col_rd_q == COL_GRAY) begin
					stat.done  = 1'b1;
					stat.found = 1'b1;
					depth_d    = '0;
					state_d    = D_IDLE;
				end else if (col_rd_q == COL_WHITE && depth_q < NW'(MAX_VERTICES)) begin
					stk_we  = 1'b1;
					col_we  = 1'b1;
					col_wa  = nb_q;
					col_wd  = COL_GRAY;
					here_d  = nb_q;
					next_d  = '0;
					depth_d = depth_q + NW'(1);
					rd_en   = 1'b1;
					rd_addr = nb_q;
				end
			end
			D_POP: begin
				here_d  = stk_rd_q[SW-1:NW];
				next_d  = stk_rd_q[NW-1:0];
				rd_en   = 1'b1;
				rd_addr = stk_rd_q[SW-1:NW];
				state_d = D_SCAN;
			end
			default: begin
				state_d = D_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			depth_q <= '0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
		end
	end

	always_ff @(posedge clk) begin
		root_q <= root_d;
		next_q <= next_d;
		here_q <= here_d;
		nb_q   <= nb_d;
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			colour_mem[col_wa] <= col_wd;
		end
		if (col_re) begin
			col_rd_q <= colour_mem[col_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_wa] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stack_mem[stk_ra];
		end
	end

endmodule

/* design/directed_graph_cycle_detect_unit.sv */
// Top level of the directed graph cycle detector: command sequencing and result register.
// Instantiates dgcd_adj and dgcd_dfs. Depends on dgcd_pkg and the interfaces in dgcd_ifs.
//
//   channel  dir  payload                            use
//   req      in   cmd, src_vertex, dst_vertex        add edge, check for cycle, clear
//   rsp      out  has_cycle, status                  one response per request
//   cfg      in   vertex_count                       vertex count register write
//
// An add edge does a read-modify-write of the source row before its response;
// a rejected edge or unused command goes straight to the response. A clear lasts
// as long as the row sweep of the adjacency memory. A check lasts as long as the
// search, which tests one matrix bit per cycle, pausing to read a colour per edge followed.
// After reset a clearing pass over every row runs before the first request is taken.
// A waiting response does not stop the next request from being accepted.
module directed_graph_cycle_detect_unit import dgcd_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dgcd_req_if.sink    req,
	dgcd_rsp_if.source  rsp,
	dgcd_cfg_if.sink    cfg
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int LW = (NW > CNT_W) ? NW : CNT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADD  = 3'd1;
	localparam logic [2:0] ST_CLR  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_RES  = 3'd4;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        vertex_count_q;
	logic [LW-1:0]           cnt_ext;
	logic [LW-1:0]           n_ext;
	logic [NW-1:0]           n;
	logic                    accept;
	logic                    in_range;
	logic                    res_cycle_q;
	logic                    res_status_q;
	logic                    rsp_valid_q;
	logic                    rsp_has_cycle_q;
	logic                    rsp_status_q;
	logic                    rsp_load;
	adj_ctl_t                adj_ctl;
	adj_stat_t               adj_stat;
	dfs_stat_t               dfs_stat;
	logic                    dfs_start;
	logic                    dfs_rd_en;
	logic [VW-1:0]           dfs_rd_addr;
	logic [MAX_VERTICES-1:0] adj_row;

	assign cnt_ext = LW'(vertex_count_q);
	assign n_ext   = (cnt_ext > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES) : cnt_ext;
	assign n       = n_ext[NW-1:0];

	assign req.ready = (state_q == ST_IDLE) && !adj_stat.busy;
	assign accept    = req.valid && req.ready;
	assign in_range  = (LW'(req.src_vertex) < n_ext) && (LW'(req.dst_vertex) < n_ext);

	assign adj_ctl.add   = accept && (req.cmd == CMD_ADD) && in_range;
	assign adj_ctl.clear = accept && (req.cmd == CMD_CLEAR);
	assign adj_ctl.src   = req.src_vertex;
	assign adj_ctl.dst   = req.dst_vertex;
	assign dfs_start     = accept && (req.cmd == CMD_CHECK);

	assign cfg.ready = 1'b1;
	assign rsp_load  = (state_q == ST_RES) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RST;
		end else if (cfg.valid && cfg.ready) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_ADD:   state_q <= in_range ? ST_ADD : ST_RES;
							CMD_CHECK: state_q <= ST_CHK;
							CMD_CLEAR: state_q <= ST_CLR;
							default:   state_q <= ST_RES;
						endcase
					end
				end
				ST_ADD, ST_CLR: begin
					if (adj_stat.done) begin
						state_q <= ST_RES;
					end
				end
				ST_CHK: begin
					if (dfs_stat.done) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_cycle_q  <= 1'b0;
			res_status_q <= (req.cmd == CMD_ADD) && !in_range;
		end else if (state_q == ST_CHK && dfs_stat.done) begin
			res_cycle_q <= dfs_stat.found;
		end
		if (rsp_load) begin
			rsp_has_cycle_q <= res_cycle_q;
			rsp_status_q    <= res_status_q;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.has_cycle = rsp_has_cycle_q;
	assign rsp.status    = rsp_status_q;

	dgcd_adj #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_adj (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (adj_ctl),
		.rd_en   (dfs_rd_en),
		.rd_addr (dfs_rd_addr),
		.row     (adj_row),
		.stat    (adj_stat)
	);

	dgcd_dfs #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dfs (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dfs_start),
		.n       (n),
		.rd_en   (dfs_rd_en),
		.rd_addr (dfs_rd_addr),
		.row     (adj_row),
		.stat    (dfs_stat)
	);

	a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while another was in progress");

	a_search_done_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		dfs_stat.done |-> state_q == ST_CHK)
		else $error("search finished outside a check");

	a_no_cycle_with_reject: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.has_cycle && rsp.status))
		else $error("response flags a cycle and a rejected edge together");

	a_no_overlap_of_units: assert property (@(posedge clk) disable iff (!arst_n)
		!(dfs_rd_en && adj_ctl.add))
		else $error("search and edge insertion read the matrix together");

endmodule

/* tb/sv/tb_directed_graph_cycle_detect_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for directed_graph_cycle_detect_unit: add edge, check, clear and
// unused requests are driven with random pacing while a local graph model predicts each
// response. Depends on dgcd_pkg and the channel interfaces in dgcd_ifs.
module tb_directed_graph_cycle_detect_unit;
	import dgcd_pkg::*;

	localparam int                 CYCLE_LIMIT  = 10_000_000;
	localparam int                 RANDOM_ITEMS = 1200;
	localparam int                 GRAPH_MAX    = MAX_VERTICES_DEF;
	localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [VTX_W-1:0] src;
		logic [VTX_W-1:0] dst;
	} graph_req_t;

	typedef struct packed {
		logic has_cycle;
		logic status;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dgcd_req_if req_ch ();
	dgcd_rsp_if rsp_ch ();
	dgcd_cfg_if cfg_ch ();

	directed_graph_cycle_detect_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	graph_req_t        pend_q[$];
	verdict_t          verdict_q[$];
	logic [GRAPH_MAX-1:0] edge_rows [GRAPH_MAX];
	int                vertex_cfg = VERTEX_COUNT_RST;
	int                fail_count = 0;
	int                cycle_count = 0;
	int                issued = 0;
	int                gap_left = 0;
	int                burst_left = 1;
	int                stall_left = 0;
	bit                hold_for_drain = 1'b0;
	bit                smooth = 1'b0;

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_directed_graph_cycle_detect_unit: FAIL");
			$finish;
		end
	end

	// Three-colour depth-first search over the vertices below n.
	function automatic logic find_back_edge(input int n);
		logic [1:0] colour [GRAPH_MAX];
		int stk_vertex [GRAPH_MAX];
		int stk_next [GRAPH_MAX];
		int depth, top, here, nx, nb;
		bit descended;
		for (int v = 0; v < n; v++)
			colour[v] = COL_WHITE;
		for (int root = 0; root < n; root++) begin
			if (colour[root] != COL_WHITE)
				continue;
			colour[root] = COL_GRAY;
			stk_vertex[0] = root;
			stk_next[0] = 0;
			depth = 1;
			while (depth > 0) begin
				top = depth - 1;
				here = stk_vertex[top];
				nx = stk_next[top];
				descended = 1'b0;
				while (nx < n) begin
					nb = nx;
					nx++;
					if (!edge_rows[here][nb])
						continue;
					if (colour[nb] == COL_GRAY)
						return 1'b1;
					if (colour[nb] == COL_WHITE && depth < GRAPH_MAX) begin
						stk_next[top] = nx;
						colour[nb] = COL_GRAY;
						stk_vertex[depth] = nb;
						stk_next[depth] = 0;
						depth++;
						descended = 1'b1;
						break;
					end
				end
				if (!descended) begin
					colour[here] = COL_BLACK;
					depth--;
				end
			end
		end
		return 1'b0;
	endfunction

	function automatic verdict_t predict_verdict(input graph_req_t r);
		verdict_t v;
		int n;
		v = '0;
		n = (vertex_cfg > GRAPH_MAX) ? GRAPH_MAX : vertex_cfg;
		case (r.cmd)
			CMD_ADD: begin
				if (r.src < n && r.dst < n)
					edge_rows[r.src][r.dst] = 1'b1;
				else
					v.status = 1'b1;
			end
			CMD_CHECK: begin
				v.has_cycle = find_back_edge(n);
			end
			CMD_CLEAR: begin
				for (int i = 0; i < GRAPH_MAX; i++)
					edge_rows[i] = '0;
			end
			default: ;
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : request_driver
		graph_req_t head;
		logic busy;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= CMD_ADD;
			req_ch.src_vertex <= '0;
			req_ch.dst_vertex <= '0;
			gap_left = 0;
			burst_left = 1;
		end else begin
			busy = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				verdict_q = {verdict_q, predict_verdict(pend_q.pop_front())};
				busy = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0 && !smooth) begin
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15)
						: $urandom_range(0, 3);
					burst_left = $urandom_range(1, 12);
				end
				if (!smooth && $urandom_range(0, 79) == 0)
					hold_for_drain = 1'b1;
			end
			if (!busy) begin
				if (hold_for_drain && verdict_q.size() == 0)
					hold_for_drain = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (!hold_for_drain && pend_q.size() > 0) begin
					head = pend_q[0];
					busy = 1'b1;
					req_ch.cmd <= head.cmd;
					req_ch.src_vertex <= head.src;
					req_ch.dst_vertex <= head.dst;
				end
			end
			req_ch.valid <= busy;
		end
	end

	always @(posedge clk or negedge arst_n) begin : response_monitor
		verdict_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (verdict_q.size() == 0) begin
					$error("response arrived with no request outstanding");
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (rsp_ch.has_cycle !== want.has_cycle) begin
						$error("has_cycle: expected %0b, actual %0b",
							want.has_cycle, rsp_ch.has_cycle);
						fail_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0b, actual %0b", want.status, rsp_ch.status);
						fail_count++;
					end
				end
			end
			if (smooth) begin
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3);
			end
		end
	end

	task automatic queue_request(input logic [CMD_W-1:0] op, input int tail, input int head);
		graph_req_t r;
		r.cmd = op;
		r.src = tail[VTX_W-1:0];
		r.dst = head[VTX_W-1:0];
		pend_q = {pend_q, r};
		issued++;
	endtask

	task automatic wait_idle();
		while (pend_q.size() != 0 || req_ch.valid || verdict_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_vertex_count(input int value);
		wait_idle();
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.vertex_count <= value[CNT_W-1:0];
		do @(posedge clk); while (!cfg_ch.ready);
		vertex_cfg = value;
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// A graph load followed by a check. Acyclic loads follow a rotated order, bar random adds.
	task automatic queue_graph_sequence(input int n);
		int edges, rot, a, b, pick;
		bit acyclic;
		acyclic = $urandom_range(0, 1);
		rot = $urandom_range(0, 63);
		if ($urandom_range(0, 3) != 0)
			queue_request(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
		edges = $urandom_range(1, 24);
		for (int i = 0; i < edges; i++) begin
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				queue_request(CMD_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
			end else if (pick == 1 || n == 0) begin
				queue_request(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
			end else if (pick == 2) begin
				queue_request(CMD_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
			end else begin
				a = $urandom_range(0, n - 1);
				b = $urandom_range(0, n - 1);
				if (!acyclic)
					queue_request(CMD_ADD, a, b);
				else if (a != b && (a + rot) % n < (b + rot) % n)
					queue_request(CMD_ADD, a, b);
				else if (a != b)
					queue_request(CMD_ADD, b, a);
			end
		end
		if (!acyclic && n > 0 && $urandom_range(0, 1) == 0)
			queue_request(CMD_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
		queue_request(CMD_CHECK, $urandom_range(0, 63), $urandom_range(0, 63));
	endtask

	initial begin
		int cnt, seqs;
		cfg_ch.valid = 1'b0;
		cfg_ch.vertex_count = VERTEX_COUNT_RST;
		for (int i = 0; i < GRAPH_MAX; i++)
			edge_rows[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_request(CMD_CHECK, 0, 0);
		queue_request(CMD_ADD, 0, 63);
		queue_request(CMD_ADD, 63, 0);
		queue_request(CMD_CHECK, 63, 63);
		queue_request(CMD_CLEAR, 63, 63);
		queue_request(CMD_CHECK, 0, 0);
		queue_request(CMD_ADD, 5, 5);
		queue_request(CMD_CHECK, 0, 0);
		queue_request(CMD_UNUSED, 63, 0);
		queue_request(CMD_CLEAR, 0, 0);
		queue_request(CMD_ADD, 40, 41);
		queue_request(CMD_ADD, 41, 40);
		queue_request(CMD_ADD, 40, 41);
		write_vertex_count(4);
		queue_request(CMD_ADD, 4, 0);
		queue_request(CMD_ADD, 0, 4);
		queue_request(CMD_CHECK, 0, 0);
		write_vertex_count(GRAPH_MAX);
		queue_request(CMD_CHECK, 0, 0);
		write_vertex_count(4);
		queue_request(CMD_CLEAR, 0, 0);
		write_vertex_count(GRAPH_MAX);
		queue_request(CMD_CHECK, 0, 0);
		write_vertex_count(0);
		queue_request(CMD_ADD, 0, 0);
		queue_request(CMD_CHECK, 0, 0);
		write_vertex_count(127);
		queue_request(CMD_ADD, 63, 63);
		queue_request(CMD_CHECK, 0, 0);
		write_vertex_count(1);
		queue_request(CMD_ADD, 0, 0);
		queue_request(CMD_CHECK, 0, 0);
		wait_idle();

		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			case ($urandom_range(0, 11))
				0:       cnt = GRAPH_MAX;
				1:       cnt = 1;
				2:       cnt = 2;
				3:       cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				4:       cnt = $urandom_range(GRAPH_MAX + 1, 127);
				5, 6:    cnt = $urandom_range(1, GRAPH_MAX);
				default: cnt = $urandom_range(1, 16);
			endcase
			write_vertex_count(cnt);
			smooth = ($urandom_range(0, 4) == 0);
			seqs = $urandom_range(1, 4);
			for (int s = 0; s < seqs; s++)
				queue_graph_sequence((cnt > GRAPH_MAX) ? GRAPH_MAX : cnt);
			wait_idle();
			smooth = 1'b0;
		end

		repeat (20) @(negedge clk);
		if (fail_count == 0 && verdict_q.size() == 0)
			$display("tb_directed_graph_cycle_detect_unit: PASS");
		else
			$display("tb_directed_graph_cycle_detect_unit: FAIL");
		$finish;
	end

endmodule

/* directed_graph_cycle_detect_unit.f */
design/dgcd_pkg.sv
design/dgcd_ifs.sv
design/dgcd_adj.sv
design/dgcd_dfs.sv
design/directed_graph_cycle_detect_unit.sv
tb/sv/tb_directed_graph_cycle_detect_unit.sv
